// ===== hdl/mlcs_pkg.sv =====
`timescale 1ns / 1ps

package mlcs_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DELAY_W    = 24;
  localparam int CNT_W      = 8;
  localparam int MDELAY_W   = 16;
  localparam int PHASE_W    = 4;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_LINK      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BROKER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_2ND   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_3RD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_MID   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_LONG  = 3'd5;

  localparam logic [CNT_W-1:0]      RST_MAX_ATTEMPTS  = 8'd5;
  localparam logic [DELAY_W-1:0]    RST_BACKOFF_2ND   = 24'd300000;
  localparam logic [DELAY_W-1:0]    RST_BACKOFF_3RD   = 24'd900000;
  localparam logic [DELAY_W-1:0]    RST_BACKOFF_MID   = 24'd1800000;
  localparam logic [DELAY_W-1:0]    RST_BACKOFF_LONG  = 24'd3600000;

  localparam logic [DELAY_W-1:0] DLY_PWR_ON     = 24'd1500;
  localparam logic [DELAY_W-1:0] DLY_SERIAL     = 24'd150;
  localparam logic [DELAY_W-1:0] DLY_CONNECTED  = 24'd100;
  localparam logic [DELAY_W-1:0] DLY_LINK_RETRY = 24'd2000;
  localparam logic [DELAY_W-1:0] DLY_BRK_RETRY  = 24'd500;
  localparam logic [DELAY_W-1:0] DLY_PWR_OFF    = 24'd3000;
  localparam logic [DELAY_W-1:0] DLY_RECONNECT  = 24'd200;
  localparam logic [DELAY_W-1:0] DLY_FIRST_OFF  = 24'd200;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  localparam logic [1:0] VERDICT_STAY    = 2'd0;
  localparam logic [1:0] VERDICT_ADVANCE = 2'd1;
  localparam logic [1:0] VERDICT_ERROR   = 2'd2;

  localparam logic OP_TIMER = 1'b0;
  localparam logic OP_MEAS  = 1'b1;

  localparam logic [PHASE_W-1:0] CODE_PWR_ON  = 4'd0;
  localparam logic [PHASE_W-1:0] CODE_SERIAL  = 4'd1;
  localparam logic [PHASE_W-1:0] CODE_RESTART = 4'd2;
  localparam logic [PHASE_W-1:0] CODE_WAITNET = 4'd3;
  localparam logic [PHASE_W-1:0] CODE_LINK    = 4'd4;
  localparam logic [PHASE_W-1:0] CODE_BROKER  = 4'd5;
  localparam logic [PHASE_W-1:0] CODE_RUN     = 4'd6;
  localparam logic [PHASE_W-1:0] CODE_ERR     = 4'd7;
  localparam logic [PHASE_W-1:0] CODE_PWR_OFF = 4'd8;

  typedef enum logic [8:0] {
    PH_PWR_ON  = 9'b000000001,
    PH_SERIAL  = 9'b000000010,
    PH_RESTART = 9'b000000100,
    PH_WAITNET = 9'b000001000,
    PH_LINK    = 9'b000010000,
    PH_BROKER  = 9'b000100000,
    PH_RUN     = 9'b001000000,
    PH_ERR     = 9'b010000000,
    PH_PWR_OFF = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0]   max_link;
    logic [CNT_W-1:0]   max_broker;
    logic [DELAY_W-1:0] backoff_2nd;
    logic [DELAY_W-1:0] backoff_3rd;
    logic [DELAY_W-1:0] backoff_mid;
    logic [DELAY_W-1:0] backoff_long;
  } cfg_t;

  typedef struct packed {
    phase_t           phase;
    logic [CNT_W-1:0] link_fail;
    logic [CNT_W-1:0] broker_fail;
    logic [CNT_W-1:0] restart_fail;
    logic [CNT_W-1:0] power_cycle;
  } seq_state_t;

  typedef struct packed {
    logic                op;
    logic [1:0]          verdict;
    logic                mon_failed;
    logic [MDELAY_W-1:0] mon_delay;
    logic                link_ok;
    logic                broker_ok;
    logic                broker_up;
    logic                publish_ok;
    logic                network_up;
    logic                link_up;
  } in_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               timer_armed;
    logic [DELAY_W-1:0] delay_ms;
    logic [CNT_W-1:0]   hw_reset_count;
    logic [CNT_W-1:0]   restart_failures;
  } out_item_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

  function automatic phase_t reconnect_phase(input logic net_up, input logic link_up);
    if (!net_up) begin
      reconnect_phase = PH_WAITNET;
    end else if (!link_up) begin
      reconnect_phase = PH_LINK;
    end else begin
      reconnect_phase = PH_BROKER;
    end
  endfunction

  function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
    unique case (ph)
      PH_PWR_ON:  phase_code = CODE_PWR_ON;
      PH_SERIAL:  phase_code = CODE_SERIAL;
      PH_RESTART: phase_code = CODE_RESTART;
      PH_WAITNET: phase_code = CODE_WAITNET;
      PH_LINK:    phase_code = CODE_LINK;
      PH_BROKER:  phase_code = CODE_BROKER;
      PH_RUN:     phase_code = CODE_RUN;
      PH_ERR:     phase_code = CODE_ERR;
      PH_PWR_OFF: phase_code = CODE_PWR_OFF;
      default:    phase_code = CODE_PWR_ON;
    endcase
  endfunction

endpackage

// ===== hdl/modem_link_connection_sequencer.sv =====
`timescale 1ns / 1ps

// Modem link connection sequencer.
// Input stream: one transaction per event. in_tuser carries the event kind
// (timer expiry or measurement arrival); in_tdata carries the outside check
// results. Output stream: one transaction per input transaction with the new
// phase, the timer to arm and the two status counters.
// Configuration: write cfg_we with cfg_addr/cfg_wdata while the block is idle;
// writes take effect on the next clock edge.
// Path: an accepted transaction is held in the input register and its result
// is then loaded into the result register that drives out_tvalid/out_tdata.
// Throughput: one transaction per cycle while out_tready stays high; the
// phase and counter update is a single level of compare and select logic
// between the two registers.
// Reset: phase returns to power on, all counters clear, configuration takes
// its default values, both channels go empty.
// Stall: while out_tready is low the result register holds, the input
// register holds its item, and in_tready drops once both are full.

module modem_link_connection_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mlcs_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [mlcs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [1:0] monitor_verdict, [2] monitor_failed, [18:3] monitor_delay_ms,
  // [19] link_connect_ok, [20] broker_connect_ok, [21] broker_up,
  // [22] publish_ok, [23] network_up, [24] link_up, [31:25] zero
  input  logic [mlcs_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] op
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [3:0] phase, [4] timer_armed, [28:5] delay_ms, [36:29] hw_reset_count,
  // [44:37] restart_failures, [47:45] zero
  output logic [mlcs_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import mlcs_pkg::*;

  cfg_t       cfg;
  seq_state_t st_r;
  seq_state_t st_nxt;
  in_item_t   item_r;
  logic       item_vld_r;
  out_item_t  res;
  out_item_t  res_r;
  logic       res_vld_r;
  logic       advance;

  mlcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mlcs_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign advance   = item_vld_r && (!res_vld_r || out_tready);
  assign in_tready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.op         <= in_tuser;
      item_r.verdict    <= in_tdata[1:0];
      item_r.mon_failed <= in_tdata[2];
      item_r.mon_delay  <= in_tdata[18:3];
      item_r.link_ok    <= in_tdata[19];
      item_r.broker_ok  <= in_tdata[20];
      item_r.broker_up  <= in_tdata[21];
      item_r.publish_ok <= in_tdata[22];
      item_r.network_up <= in_tdata[23];
      item_r.link_up    <= in_tdata[24];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase        <= PH_PWR_ON;
      st_r.link_fail    <= '0;
      st_r.broker_fail  <= '0;
      st_r.restart_fail <= '0;
      st_r.power_cycle  <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= 1'b1;
    end else if (out_tready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {3'b000, res_r.restart_failures, res_r.hw_reset_count,
                       res_r.delay_ms, res_r.timer_armed, res_r.phase};

endmodule

// ===== hdl/mlcs_cfg_regs.sv =====
`timescale 1ns / 1ps

module mlcs_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mlcs_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [mlcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output mlcs_pkg::cfg_t                  cfg
);
  import mlcs_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_link     <= RST_MAX_ATTEMPTS;
      cfg_r.max_broker   <= RST_MAX_ATTEMPTS;
      cfg_r.backoff_2nd  <= RST_BACKOFF_2ND;
      cfg_r.backoff_3rd  <= RST_BACKOFF_3RD;
      cfg_r.backoff_mid  <= RST_BACKOFF_MID;
      cfg_r.backoff_long <= RST_BACKOFF_LONG;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MAX_LINK:     cfg_r.max_link     <= cfg_wdata[CNT_W-1:0];
        REG_MAX_BROKER:   cfg_r.max_broker   <= cfg_wdata[CNT_W-1:0];
        REG_BACKOFF_2ND:  cfg_r.backoff_2nd  <= cfg_wdata[DELAY_W-1:0];
        REG_BACKOFF_3RD:  cfg_r.backoff_3rd  <= cfg_wdata[DELAY_W-1:0];
        REG_BACKOFF_MID:  cfg_r.backoff_mid  <= cfg_wdata[DELAY_W-1:0];
        REG_BACKOFF_LONG: cfg_r.backoff_long <= cfg_wdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/mlcs_step.sv =====
`timescale 1ns / 1ps

module mlcs_step (
  input  mlcs_pkg::cfg_t       cfg,
  input  mlcs_pkg::seq_state_t st,
  input  mlcs_pkg::in_item_t   item,
  output mlcs_pkg::seq_state_t st_nxt,
  output mlcs_pkg::out_item_t  res
);
  import mlcs_pkg::*;

  logic               armed;
  logic [DELAY_W-1:0] delay;
  logic [DELAY_W-1:0] mdelay;
  logic [CNT_W-1:0]   link_inc;
  logic [CNT_W-1:0]   broker_inc;
  logic [DELAY_W-1:0] backoff;

  assign mdelay     = {{(DELAY_W-MDELAY_W){1'b0}}, item.mon_delay};
  assign link_inc   = sat_inc(st.link_fail);
  assign broker_inc = sat_inc(st.broker_fail);

  always_comb begin
    priority if (st.power_cycle == '0) begin
      backoff = DLY_FIRST_OFF;
    end else if (st.power_cycle == 8'd1) begin
      backoff = cfg.backoff_2nd;
    end else if (st.power_cycle == 8'd2) begin
      backoff = cfg.backoff_3rd;
    end else if (st.power_cycle[CNT_W-1:3] == '0) begin
      backoff = cfg.backoff_mid;
    end else begin
      backoff = cfg.backoff_long;
    end
  end

  always_comb begin
    st_nxt = st;
    armed  = 1'b1;
    delay  = '0;
    if (item.op == OP_MEAS) begin
      if (st.phase == PH_RUN && (!item.broker_up || !item.publish_ok)) begin
        st_nxt.phase = reconnect_phase(item.network_up, item.link_up);
        delay        = DLY_RECONNECT;
      end else begin
        armed = 1'b0;
      end
    end else begin
      unique case (st.phase)
        PH_PWR_ON: begin
          st_nxt.link_fail    = '0;
          st_nxt.broker_fail  = '0;
          st_nxt.restart_fail = '0;
          st_nxt.phase        = PH_SERIAL;
          delay               = DLY_PWR_ON;
        end
        PH_SERIAL: begin
          st_nxt.phase = PH_RESTART;
          delay        = DLY_SERIAL;
        end
        PH_RESTART: begin
          if (item.verdict == VERDICT_ADVANCE) begin
            st_nxt.phase = PH_WAITNET;
          end else if (item.verdict == VERDICT_ERROR) begin
            st_nxt.phase = PH_ERR;
            if (item.mon_failed) st_nxt.restart_fail = sat_inc(st.restart_fail);
          end
          delay = mdelay;
        end
        PH_WAITNET: begin
          if (item.verdict == VERDICT_ADVANCE) begin
            st_nxt.phase = PH_LINK;
          end else if (item.verdict == VERDICT_ERROR) begin
            st_nxt.phase = PH_RESTART;
          end
          delay = mdelay;
        end
        PH_LINK: begin
          if (item.link_ok) begin
            st_nxt.phase = PH_BROKER;
            delay        = DLY_CONNECTED;
          end else begin
            st_nxt.link_fail = link_inc;
            if (link_inc >= cfg.max_link) st_nxt.phase = PH_RESTART;
            delay = DLY_LINK_RETRY;
          end
        end
        PH_BROKER: begin
          if (item.broker_ok) begin
            st_nxt.phase        = PH_RUN;
            st_nxt.link_fail    = '0;
            st_nxt.broker_fail  = '0;
            st_nxt.restart_fail = '0;
            delay               = DLY_CONNECTED;
          end else begin
            st_nxt.broker_fail = broker_inc;
            if (broker_inc >= cfg.max_broker) st_nxt.phase = PH_LINK;
            delay = DLY_BRK_RETRY;
          end
        end
        PH_RUN: begin
          st_nxt.power_cycle = '0;
          if (item.verdict == VERDICT_ADVANCE) begin
            st_nxt.phase = reconnect_phase(item.network_up, item.link_up);
            delay        = DLY_RECONNECT;
          end else begin
            delay = mdelay;
          end
        end
        PH_ERR: begin
          st_nxt.phase        = PH_PWR_OFF;
          st_nxt.link_fail    = '0;
          st_nxt.broker_fail  = '0;
          st_nxt.restart_fail = '0;
          delay               = backoff;
        end
        PH_PWR_OFF: begin
          st_nxt.power_cycle = sat_inc(st.power_cycle);
          st_nxt.phase       = PH_PWR_ON;
          delay              = DLY_PWR_OFF;
        end
        default: begin
          armed = 1'b0;
        end
      endcase
    end
  end

  assign res.phase            = phase_code(st_nxt.phase);
  assign res.timer_armed      = armed;
  assign res.delay_ms         = armed ? delay : '0;
  assign res.hw_reset_count   = st_nxt.power_cycle;
  assign res.restart_failures = st_nxt.restart_fail;

endmodule
